### hdl/vnfs_pkg.sv
package vnfs_pkg;

	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;

	// multiply-xor lattice hash
	localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
	localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

	localparam int CORNER_W = 24;             // Q0.24 corner and blend value
	localparam int TERM_W   = CORNER_W + 1;   // ridged term reaches 1.0
	localparam int WEIGHT_W = 17;             // smoothstep weight, 0..65536
	localparam int LANE_STAGES = 10;

	localparam logic [TERM_W-1:0] ONE_Q24 = TERM_W'(1) << CORNER_W;

	typedef enum logic {
		OP_FBM    = 1'b0,
		OP_RIDGED = 1'b1
	} op_t;

endpackage

### hdl/vnfs_octave.sv
module vnfs_octave
	import vnfs_pkg::*;
#(
	parameter int LANE      = 0,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [31:0]         x_coord,
	input  logic signed [31:0]         z_coord,
	output logic        [CORNER_W-1:0] n_s10,
	output logic        [TERM_W-1:0]   ridge_s10
);

	// stage 1: scale by 2^LANE, split lattice index and fraction
	logic [63:0] sx_full, sz_full;
	logic [FRAC_BITS+15:0] fx_ext, fz_ext;
	logic [31:0] xi_s1, x1_s1, zi_s1, z1_s1;
	logic [15:0] tx_s1, tz_s1;

	always_comb begin
		sx_full = 64'($signed(x_coord)) << LANE;
		sz_full = 64'($signed(z_coord)) << LANE;
		fx_ext  = {sx_full[FRAC_BITS-1:0], 16'b0};
		fz_ext  = {sz_full[FRAC_BITS-1:0], 16'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xi_s1 <= sx_full[FRAC_BITS+31:FRAC_BITS];
			x1_s1 <= sx_full[FRAC_BITS+31:FRAC_BITS] + 32'd1;
			zi_s1 <= sz_full[FRAC_BITS+31:FRAC_BITS];
			z1_s1 <= sz_full[FRAC_BITS+31:FRAC_BITS] + 32'd1;
			tx_s1 <= fx_ext[FRAC_BITS+15:FRAC_BITS];
			tz_s1 <= fz_ext[FRAC_BITS+15:FRAC_BITS];
		end
	end

	// stage 2: hash products, t*t
	logic [31:0] px0_s2, px1_s2, pz0_s2, pz1_s2;
	logic [31:0] ttx_s2, ttz_s2;
	logic [15:0] tx_s2, tz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px0_s2 <= 32'(xi_s1 * HASH_MUL_X);
			px1_s2 <= 32'(x1_s1 * HASH_MUL_X);
			pz0_s2 <= 32'(zi_s1 * HASH_MUL_Z);
			pz1_s2 <= 32'(z1_s1 * HASH_MUL_Z);
			ttx_s2 <= 32'(tx_s1) * 32'(tx_s1);
			ttz_s2 <= 32'(tz_s1) * 32'(tz_s1);
			tx_s2  <= tx_s1;
			tz_s2  <= tz_s1;
		end
	end

	// stage 3: combine and first xor-shift; t*t*(3-2t) in Q0.48
	logic [31:0] hs [4];
	logic [31:0] h_s3 [4];
	logic [49:0] px_s3, pz_s3;

	always_comb begin
		hs[0] = px0_s2 + pz0_s2;
		hs[1] = px1_s2 + pz0_s2;
		hs[2] = px0_s2 + pz1_s2;
		hs[3] = px1_s2 + pz1_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				h_s3[k] <= hs[k] ^ (hs[k] >> 13);
			end
			px_s3 <= 50'(ttx_s2) * 50'(18'd196608 - {1'b0, tx_s2, 1'b0});
			pz_s3 <= 50'(ttz_s2) * 50'(18'd196608 - {1'b0, tz_s2, 1'b0});
		end
	end

	// stage 4: mixing multiply; round weights to Q0.16
	logic [31:0] hm_s4 [4];
	logic [WEIGHT_W-1:0] wx_s4, wz_s4;
	logic [49:0] rx_sum, rz_sum;

	always_comb begin
		rx_sum = px_s3 + (50'd1 << 31);
		rz_sum = pz_s3 + (50'd1 << 31);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				hm_s4[k] <= 32'(h_s3[k] * HASH_MUL_MIX);
			end
			wx_s4 <= rx_sum[32+WEIGHT_W-1:32];
			wz_s4 <= rz_sum[32+WEIGHT_W-1:32];
		end
	end

	// stage 5: corner values, weight product
	logic [CORNER_W-1:0] cv_s5 [4];
	logic [WEIGHT_W-1:0] wx_s5, wz_s5;
	logic [2*WEIGHT_W-1:0] wxz_s5;
	logic [31:0] hf [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			hf[k] = hm_s4[k] ^ (hm_s4[k] >> 16);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				cv_s5[k] <= hf[k][CORNER_W-1:0];
			end
			wxz_s5 <= (2*WEIGHT_W)'(wx_s4) * (2*WEIGHT_W)'(wz_s4);
			wx_s5  <= wx_s4;
			wz_s5  <= wz_s4;
		end
	end

	// stage 6: corner differences
	logic signed [CORNER_W:0]   ba_s6, ca_s6;
	logic signed [CORNER_W+1:0] abcd_s6;
	logic [CORNER_W-1:0]        a_s6;
	logic [WEIGHT_W-1:0]        wx_s6, wz_s6;
	logic [2*WEIGHT_W-1:0]      wxz_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ba_s6   <= $signed({1'b0, cv_s5[1]}) - $signed({1'b0, cv_s5[0]});
			ca_s6   <= $signed({1'b0, cv_s5[2]}) - $signed({1'b0, cv_s5[0]});
			abcd_s6 <= $signed({2'b0, cv_s5[0]}) - $signed({2'b0, cv_s5[1]})
				- $signed({2'b0, cv_s5[2]}) + $signed({2'b0, cv_s5[3]});
			a_s6    <= cv_s5[0];
			wx_s6   <= wx_s5;
			wz_s6   <= wz_s5;
			wxz_s6  <= wxz_s5;
		end
	end

	// stage 7: blend products
	logic signed [63:0] m1_s7, m2_s7, m3_s7;
	logic [CORNER_W-1:0] a_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s7 <= 64'(ba_s6) * $signed(64'(wx_s6));
			m2_s7 <= 64'(ca_s6) * $signed(64'(wz_s6));
			m3_s7 <= 64'(abcd_s6) * $signed(64'(wxz_s6));
			a_s7  <= a_s6;
		end
	end

	// stage 8: sum in Q0.56, round to Q0.24, clamp
	logic signed [63:0] v_sum;
	logic [63:0] v_rnd;
	logic [CORNER_W-1:0] n_s8;

	always_comb begin
		v_sum = $signed(64'(a_s7) << 32) + (m1_s7 <<< 16) + (m2_s7 <<< 16) + m3_s7;
		v_rnd = (v_sum < 0) ? 64'd0 : (64'(v_sum) + (64'd1 << 31)) >> 32;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s8 <= (v_rnd > 64'(CORNER_W'('1))) ? CORNER_W'('1) : v_rnd[CORNER_W-1:0];
		end
	end

	// stage 9: ridge fold and square
	logic [TERM_W-1:0] two_n, fold_d, ridge_r;
	logic [2*TERM_W-1:0] rr_s9;
	logic [CORNER_W-1:0] n_s9;

	always_comb begin
		two_n   = {n_s8, 1'b0};
		fold_d  = (two_n >= ONE_Q24) ? two_n - ONE_Q24 : ONE_Q24 - two_n;
		ridge_r = ONE_Q24 - fold_d;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s9 <= (2*TERM_W)'(ridge_r) * (2*TERM_W)'(ridge_r);
			n_s9  <= n_s8;
		end
	end

	// stage 10: round square to Q0.24
	logic [2*TERM_W-1:0] rr_rnd;

	assign rr_rnd = rr_s9 + ((2*TERM_W)'(1) << (CORNER_W-1));

	always_ff @(posedge clk) begin
		if (en) begin
			ridge_s10 <= rr_rnd[CORNER_W+TERM_W-1:CORNER_W];
			n_s10     <= n_s9;
		end
	end

endmodule

### hdl/value_noise_fractal_sum_unit.sv
// Throughput: one item per cycle while the output is not stalled; every
// octave has its own lane, so the octave count does not change the rate.
// Reset: arst_n clears the stage valid bits at once; data registers keep no reset.
// A stalled output that holds a valid result holds every stage.
module value_noise_fractal_sum_unit
	import vnfs_pkg::*;
#(
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [3:0]         octaves,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] z_coord,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        noise_value
);

	localparam int NS  = LANE_STAGES + 5;          // total stages
	localparam int OW  = $clog2(MAX_OCTAVES + 1);  // clamped octave count
	localparam int AW  = MAX_OCTAVES + TERM_W;     // weighted sum
	localparam int K   = MAX_OCTAVES + 7;          // denominator scale
	localparam int NW  = AW + MAX_OCTAVES + 1;     // rounded numerator
	localparam int YW  = NW - K - 1;               // numerator after scale
	localparam int S   = YW + MAX_OCTAVES + 1;     // reciprocal shift
	localparam int RW  = S + 1;
	localparam int NP  = (MAX_OCTAVES + 1) / 2;    // adder tree pairs
	localparam int TAB = 2 ** OW;

	// The whole pipe moves together; only a full, stalled output holds it.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Clamp the octave count to 1..MAX_OCTAVES at the door.
	logic [OW-1:0] oct_in;
	always_comb begin
		if (octaves == 4'd0) begin
			oct_in = OW'(1);
		end else if (32'(octaves) > MAX_OCTAVES) begin
			oct_in = OW'(MAX_OCTAVES);
		end else begin
			oct_in = OW'(octaves);
		end
	end

	// Valid bits and per-item control ride alongside the data.
	logic          vld_s [1:NS];
	logic [OW-1:0] oct_s [1:13];
	op_t           op_s  [1:10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oct_s[1] <= oct_in;
			op_s[1]  <= op_t'(opcode);
			for (int k = 2; k <= 13; k++) begin
				oct_s[k] <= oct_s[k-1];
			end
			for (int k = 2; k <= 10; k++) begin
				op_s[k] <= op_s[k-1];
			end
		end
	end

	// Stages 1-10: one lane per octave, each working at frequency 2^i.
	logic [CORNER_W-1:0] lane_n  [MAX_OCTAVES];
	logic [TERM_W-1:0]   lane_rg [MAX_OCTAVES];

	for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
		vnfs_octave #(
			.LANE      (g),
			.FRAC_BITS (FRAC_BITS)
		) u_octave (
			.clk       (clk),
			.en        (en),
			.x_coord   (x_coord),
			.z_coord   (z_coord),
			.n_s10     (lane_n[g]),
			.ridge_s10 (lane_rg[g])
		);
	end

	// Stage 11: pick term by opcode, drop octaves past the count, weight by
	// 2^(MAX_OCTAVES-1-i) and add in pairs.
	logic [AW-1:0] wterm [MAX_OCTAVES];
	logic [AW-1:0] pair_s11 [NP];

	always_comb begin
		for (int i = 0; i < MAX_OCTAVES; i++) begin
			if (OW'(i) < oct_s[10]) begin
				wterm[i] = (op_s[10] == OP_RIDGED) ? AW'(lane_rg[i]) : AW'(lane_n[i]);
				wterm[i] = wterm[i] << (MAX_OCTAVES - 1 - i);
			end else begin
				wterm[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < NP; p++) begin
				if (2 * p + 1 < MAX_OCTAVES) begin
					pair_s11[p] <= wterm[2*p] + wterm[2*p+1];
				end else begin
					pair_s11[p] <= wterm[2*p];
				end
			end
		end
	end

	// Stage 12: finish the sum.
	logic [AW-1:0] acc_sum;
	logic [AW-1:0] acc_s12;

	always_comb begin
		acc_sum = '0;
		for (int p = 0; p < NP; p++) begin
			acc_sum = acc_sum + pair_s11[p];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s12 <= acc_sum;
		end
	end

	// Stage 13: fold the half-denominator rounding term in and strip the
	// power-of-two part of the denominator; what is left divides by 2^oct-1.
	// Ceiling reciprocals of 2^oct-1 are exact for every numerator here.
	logic [RW-1:0] rcp_tab [TAB];

	for (genvar g = 0; g < TAB; g++) begin : g_rcp
		localparam logic [127:0] DEN = (g >= 1 && g <= MAX_OCTAVES)
			? ((128'd1 << g) - 128'd1) : 128'd1;
		localparam logic [127:0] RCP = ((128'd1 << S) + DEN - 128'd1) / DEN;
		assign rcp_tab[g] = RW'(RCP);
	end

	logic [NW-1:0] num_sum;
	logic [YW-1:0] y_s13;
	logic [RW-1:0] rcp_s13;

	always_comb begin
		num_sum = (NW'(acc_s12) << oct_s[12])
			+ (((NW'(1) << oct_s[12]) - NW'(1)) << K);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s13   <= num_sum[NW-1:K+1];
			rcp_s13 <= rcp_tab[oct_s[12]];
		end
	end

	// Stage 14: multiply by the reciprocal.
	logic [YW+RW-1:0] prod_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s14 <= (YW+RW)'(y_s13) * (YW+RW)'(rcp_s13);
		end
	end

	// Stage 15: drop the reciprocal scale, saturate to Q0.16.
	logic [YW+RW-1:0] quot;
	logic [15:0]      q_s15;

	assign quot = prod_s14 >> S;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s15 <= (quot > (YW+RW)'(16'hFFFF)) ? 16'hFFFF : quot[15:0];
		end
	end

	assign out_valid   = vld_s[NS];
	assign noise_value = q_s15;

endmodule

### hdl/vnfs_checker.sv
module vnfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               opcode,
	input logic [3:0]         octaves,
	input logic signed [31:0] x_coord,
	input logic signed [31:0] z_coord,
	input logic               out_valid,
	input logic               out_stall,
	input logic [15:0]        noise_value
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(noise_value))
		else $error("stalled result changed");

	// back pressure reaches the input only through a held result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_stall_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while result held");

	// pipeline comes out of reset empty
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind value_noise_fractal_sum_unit vnfs_checker u_vnfs_checker (.*);

### dv/tb_value_noise_fractal_sum_unit.sv
module tb_value_noise_fractal_sum_unit;
	import vnfs_pkg::*;

	// one sample point as the sender offers it
	typedef struct {
		op_t         op;
		logic [3:0]  oct;
		logic [31:0] x;
		logic [31:0] z;
		bit          drain_first;   // hold this item until every result is back
	} sample_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 60;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = 1'b0;
	logic [3:0]         octaves = 4'd1;
	logic signed [31:0] x_coord = '0;
	logic signed [31:0] z_coord = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        noise_value;

	sample_t     pending_samples[$];
	logic [15:0] expected_noise[$];
	sample_t     offered;
	int          mismatches = 0;
	int          results_seen = 0;
	int          idle_cycles = 0;

	value_noise_fractal_sum_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .octaves(octaves), .x_coord(x_coord), .z_coord(z_coord),
		.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor: fixed-point value noise and ridged noise per octave
	// ---------------------------------------------------------------
	function automatic logic [23:0] corner_hash(logic [31:0] xi, logic [31:0] zi);
		logic [31:0] h;
		h = xi * HASH_MUL_X + zi * HASH_MUL_Z;
		h = (h ^ (h >> 13)) * HASH_MUL_MIX;
		h = h ^ (h >> 16);
		return h[23:0];
	endfunction

	// smoothstep t*t*(3-2t), exact in Q0.48, rounded half up to Q0.16
	function automatic longint fade_weight(logic [63:0] coord);
		logic [63:0] t;
		logic [63:0] p;
		t = {48'd0, coord[15:0]};
		p = t * t * (64'd196608 - 2 * t);
		return longint'((p + (64'd1 << 31)) >> 32);
	endfunction

	function automatic logic [23:0] lattice_blend(logic [63:0] px, logic [63:0] pz);
		logic [31:0] xi;
		logic [31:0] zi;
		longint sx, sz, a, b, c, d, v;
		logic [63:0] n;
		xi = px[47:16];
		zi = pz[47:16];
		sx = fade_weight(px);
		sz = fade_weight(pz);
		a = longint'(corner_hash(xi, zi));
		b = longint'(corner_hash(xi + 32'd1, zi));
		c = longint'(corner_hash(xi, zi + 32'd1));
		d = longint'(corner_hash(xi + 32'd1, zi + 32'd1));
		v = a * 64'sd4294967296 + (b - a) * sx * 65536 + (c - a) * sz * 65536
			+ (a - b - c + d) * sx * sz;
		if (v < 0)
			v = 0;
		n = (64'(v) + (64'd1 << 31)) >> 32;
		if (n > 64'hFFFFFF)
			n = 64'hFFFFFF;
		return n[23:0];
	endfunction

	function automatic logic [15:0] noise_sum_predict(sample_t s);
		logic [63:0] xs, zs, acc, n, term, two_n, diff, r, num, den, q;
		int oct;
		acc = '0;
		oct = s.oct;
		// zero octaves count as one, too many are capped
		if (oct < 1)
			oct = 1;
		if (oct > MAX_OCTAVES_DEF)
			oct = MAX_OCTAVES_DEF;
		xs = {{32{s.x[31]}}, s.x};
		zs = {{32{s.z[31]}}, s.z};
		for (int i = 0; i < oct; i++) begin
			n = {40'd0, lattice_blend(xs << i, zs << i)};
			term = n;
			if (s.op == OP_RIDGED) begin
				two_n = n * 2;
				diff = (two_n >= 64'h1000000) ? two_n - 64'h1000000 : 64'h1000000 - two_n;
				r = 64'h1000000 - diff;
				term = (r * r + (64'd1 << 23)) >> 24;
			end
			acc += term << (MAX_OCTAVES_DEF - 1 - i);
		end
		num = acc << (oct - 1);
		den = ((64'd1 << oct) - 1) << (8 + MAX_OCTAVES_DEF - 1);
		q = (num + den / 2) / den;
		if (q > 64'd65535)
			q = 64'd65535;
		return q[15:0];
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
			2: return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom())};
			3: return {16'($urandom_range(0, 3)), 16'($urandom())};
			4: return {16'($urandom()), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
			default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
		endcase
	endfunction

	task automatic add_sample(op_t op, logic [3:0] oct, logic [31:0] x, logic [31:0] z,
			bit drain = 1'b0);
		sample_t s;
		s.op = op;
		s.oct = oct;
		s.x = x;
		s.z = z;
		s.drain_first = drain;
		pending_samples = {pending_samples, s};
	endtask

	function automatic int rand_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// ---------------------------------------------------------------
	// Driver: offer queued items, hold each until accepted
	// ---------------------------------------------------------------
	int gap_left = 0;
	int burst_left = 0;

	always @(posedge clk) begin
		logic next_valid;
		next_valid = in_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				// accepted: record its expectation and move on
				expected_noise = {expected_noise, noise_sum_predict(offered)};
				void'(pending_samples.pop_front());
				next_valid = 1'b0;
				if (burst_left > 0)
					burst_left--;
				else begin
					gap_left = rand_gap();
					// now and then run a stretch with no idling at all
					if ($urandom_range(0, 19) == 0)
						burst_left = $urandom_range(20, 60);
				end
			end
			if (!next_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_samples.size() > 0) begin
					offered = pending_samples[0];
					// drain request: wait for every result before offering
					if (!offered.drain_first || expected_noise.size() == 0) begin
						next_valid = 1'b1;
						opcode <= offered.op;
						octaves <= offered.oct;
						x_coord <= offered.x;
						z_coord <= offered.z;
					end
				end
			end
		end
		in_valid <= next_valid;
	end

	// ---------------------------------------------------------------
	// Monitor: compare results in order, drive random stalls
	// ---------------------------------------------------------------
	int stall_left = 0;
	int long_hold_left = 0;
	bit long_hold_done = 1'b0;

	always @(posedge clk) begin
		logic [15:0] want;
		logic next_stall;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_noise.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: noise_value=%0d", noise_value);
			end else begin
				want = expected_noise.pop_front();
				if (noise_value !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("noise_value mismatch on item %0d: expected %0d got %0d",
							results_seen, want, noise_value);
				end
			end
		end
		// one long hold-off so the pipeline fills and stalls its input
		if (!long_hold_done && results_seen == 200) begin
			long_hold_done = 1'b1;
			long_hold_left = 300;
		end
		if (long_hold_left > 0) begin
			long_hold_left--;
			next_stall = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			next_stall = 1'b1;
		end else begin
			next_stall = 1'b0;
			if ($urandom_range(0, 3) == 0)
				stall_left = rand_gap();
		end
		out_stall <= next_stall;
	end

	// ---------------------------------------------------------------
	// Watchdog: end the run when nothing moves for too long
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("value_noise_fractal_sum_unit verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed corners, random items, drain
	// ---------------------------------------------------------------
	initial begin
		op_t op;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: octave count extremes, including zero and above the cap
		add_sample(OP_FBM, 4'd0, 32'h0001_8000, 32'h0002_4000);
		add_sample(OP_RIDGED, 4'd0, 32'h0001_8000, 32'h0002_4000);
		add_sample(OP_FBM, 4'd1, 32'h0000_0000, 32'h0000_0000);
		add_sample(OP_RIDGED, 4'd1, 32'h0000_0000, 32'h0000_0000);
		add_sample(OP_FBM, 4'd8, 32'h0003_C000, 32'hFFFE_2000);
		add_sample(OP_RIDGED, 4'd8, 32'h0003_C000, 32'hFFFE_2000);
		add_sample(OP_FBM, 4'd9, 32'h1234_5678, 32'h9ABC_DEF0);
		add_sample(OP_RIDGED, 4'd15, 32'h1234_5678, 32'h9ABC_DEF0);
		// coordinate extremes; lattice indices wrap at the top octaves
		add_sample(OP_FBM, 4'd8, 32'h8000_0000, 32'h8000_0000);
		add_sample(OP_RIDGED, 4'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_sample(OP_FBM, 4'd8, 32'h7FFF_FFFF, 32'h8000_0000);
		add_sample(OP_RIDGED, 4'd8, 32'h8000_0000, 32'h7FFF_FFFF);
		add_sample(OP_FBM, 4'd4, 32'hFFFF_FFFF, 32'h0000_FFFF);
		add_sample(OP_RIDGED, 4'd4, 32'h0000_FFFF, 32'hFFFF_FFFF);
		// half-way fractions, where smoothstep and the ridge fold are symmetric, then fractions near zero and one
		add_sample(OP_FBM, 4'd2, 32'h0000_8000, 32'h0000_8000);
		add_sample(OP_RIDGED, 4'd3, 32'h0000_8000, 32'hFFFF_8000);
		add_sample(OP_FBM, 4'd1, 32'h0000_0001, 32'hFFFF_0000);
		add_sample(OP_RIDGED, 4'd7, 32'hFFFF_FFFF, 32'h0000_0001);

		for (int k = 0; k < 850; k++) begin
			op = $urandom_range(0, 1) ? OP_RIDGED : OP_FBM;
			add_sample(op,
				($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8)),
				rand_coord(), rand_coord(),
				k == 450);
		end

		wait (pending_samples.size() == 0 && !in_valid);
		wait (expected_noise.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_noise.size() == 0)
			$display("value_noise_fractal_sum_unit verification clean");
		else
			$display("value_noise_fractal_sum_unit verification failed");
		$finish;
	end

endmodule
